FILE: src/ibt_pkg.sv
// Shared types, codes and constants of the integer bound tightening block.
package ibt_pkg;

   localparam int unsigned CsrAddrWidth = 4;
   localparam logic [CsrAddrWidth-1:0] AddrWeightFloor  = 4'h0;
   localparam logic [CsrAddrWidth-1:0] AddrReturnTarget = 4'h4;
   localparam logic [CsrAddrWidth-1:0] AddrRoundLimit   = 4'h8;
   localparam logic [15:0] RoundLimitReset = 16'd1024;

   localparam logic [63:0] SatHi = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SatLo = 64'h8000_0000_0000_0001;

   // end status codes
   localparam logic [1:0] StatusConverged  = 2'd0;
   localparam logic [1:0] StatusInfeasible = 2'd1;
   localparam logic [1:0] StatusLimit      = 2'd2;

   typedef struct packed {
      logic [5:0]         var_index;
      logic signed [31:0] weight;
      logic signed [31:0] ret_coef;
      logic signed [31:0] lower_in;
      logic signed [31:0] upper_in;
      logic               load_last;
   } req_type;

   typedef struct packed {
      logic [5:0]         out_index;
      logic signed [31:0] lower_out;
      logic signed [31:0] upper_out;
      logic [1:0]         end_status;
      logic               out_last;
   } rsp_type;

   // divider handshake
   typedef struct packed {
      logic               start;
      logic signed [63:0] num;
      logic signed [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SUM1_RD, ST_SUM1_ACC,
      ST_P1_RD, ST_P1_DIVU, ST_P1_WAITU, ST_P1_DIVL, ST_P1_WAITL, ST_P1_WR,
      ST_SUM2_RD, ST_SUM2_ACC,
      ST_P2_RD, ST_P2_DIV, ST_P2_WAIT, ST_P2_WR,
      ST_CHK_RD, ST_CHK, ST_DECIDE,
      ST_OUT_RD, ST_OUT
   } state_type;

   // saturating 64-bit add into +-(2^63-1)
   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > $signed({1'b0, SatHi})) return SatHi;
      if (s < $signed({1'b1, SatLo})) return SatLo;
      return s[63:0];
   endfunction

   // clamp a 64-bit value to 32-bit signed
   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

FILE: src/integer_bound_tightening_top.sv
// Top level: variable store, sequencer and shared divider of the bound tightening block.
//
//   port group | dir | payload
//   req_       | in  | ibt_pkg::req_type, valid/ready
//   rsp_       | out | ibt_pkg::rsp_type, valid/ready
//   csr_       | in  | APB-style, 32-bit data, weight_floor/return_target/round_limit
//
// The final loaded item starts rounds; each round walks the variables five times over one
// store read port (two sums, two tightening passes and a feasibility scan). Each division
// is one run of the shared radix-2 divider, up to three per variable. Results then go out
// one at a time, each after its own store read; a low rsp_ready holds the current result.
// req_ready stays low from the final item to the last result.
// Synchronous reset clears control state; the stores need no clearing.
module integer_bound_tightening_top #(
   parameter int MAX_VARS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ibt_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ibt_pkg::rsp_type     rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ibt_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int IW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int CW = $clog2(MAX_VARS + 1);
   localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;

   // configuration registers
   logic signed [31:0] wfloor_ff, rtarget_ff;
   logic [15:0]        rlimit_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         wfloor_ff <= '0; rtarget_ff <= '0; rlimit_ff <= ibt_pkg::RoundLimitReset;
      end else if (csr_wr) begin
         case (csr_paddr)
            ibt_pkg::AddrWeightFloor:  wfloor_ff  <= csr_pwdata;
            ibt_pkg::AddrReturnTarget: rtarget_ff <= csr_pwdata;
            ibt_pkg::AddrRoundLimit:   rlimit_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr)
         ibt_pkg::AddrWeightFloor:  csr_prdata = wfloor_ff;
         ibt_pkg::AddrReturnTarget: csr_prdata = rtarget_ff;
         ibt_pkg::AddrRoundLimit:   csr_prdata = {16'd0, rlimit_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // variable store: one 128-bit row per variable
   logic [127:0] mem [MAX_VARS];
   logic [127:0] rd_ff;
   logic [IW-1:0] raddr, waddr;
   logic          we;
   logic [127:0]  wdata;
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end
   logic signed [31:0] g_r, r_r, lo_r, up_r;
   assign {g_r, r_r, lo_r, up_r} = rd_ff;

   // sequencer state
   ibt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;   // loaded count
   logic [CW-1:0]  n_ff, n_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [15:0]    rounds_ff, rounds_in;
   logic signed [63:0] acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic signed [31:0] lo_ff, lo_in, up_ff, up_in;
   logic           chg_ff, chg_in, inf_ff, inf_in;
   logic [1:0]     status_ff, status_in;

   ibt_pkg::div_req_type dreq;
   ibt_pkg::div_rsp_type drsp;
   ibt_div u_div (.clock(clock), .reset(reset), .dreq(dreq), .drsp(drsp));

   logic signed [63:0] t_lo, t_up, delta, prod_lo, prod_up, prod_r;
   logic signed [31:0] cand;
   logic [15:0]        limit;
   logic               last_idx;

   assign prod_lo = 64'(lo_r) * 64'(g_r);
   assign prod_up = 64'(up_r) * 64'(g_r);
   assign prod_r  = r_r[31] ? 64'(r_r) * 64'(lo_r) : 64'(r_r) * 64'(up_r);
   assign t_lo  = ibt_pkg::sadd(One, -acc1_ff);
   assign t_up  = ibt_pkg::sadd(acc2_ff, -64'(wfloor_ff));
   assign delta = ibt_pkg::sadd(acc1_ff, -64'(rtarget_ff));
   assign limit = (rlimit_ff == 16'd0) ? 16'd1 : rlimit_ff;
   assign last_idx = (idx_ff + CW'(1) == n_ff);

   always_comb begin
      state_in = state_ff; count_in = count_ff; n_in = n_ff; idx_in = idx_ff;
      rounds_in = rounds_ff; acc1_in = acc1_ff; acc2_in = acc2_ff;
      lo_in = lo_ff; up_in = up_ff; chg_in = chg_ff; inf_in = inf_ff;
      status_in = status_ff;
      raddr = idx_ff[IW-1:0]; waddr = idx_ff[IW-1:0]; we = 1'b0;
      wdata = {g_r, r_r, lo_ff, up_ff};
      dreq = '0; cand = '0;
      req_ready = 1'b0; rsp_valid = 1'b0;
      case (state_ff)
         ibt_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            waddr = count_ff[IW-1:0];
            wdata = {req_data.weight, req_data.ret_coef, req_data.lower_in,
                     req_data.upper_in};
            if (req_valid) begin
               if (count_ff < CW'(MAX_VARS)) begin
                  we = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_data.load_last) begin
                  n_in = (count_ff < CW'(MAX_VARS)) ? count_ff + CW'(1) : count_ff;
                  count_in = '0;
                  rounds_in = '0;
                  idx_in = '0; acc1_in = '0; acc2_in = '0; chg_in = 1'b0;
                  state_in = ibt_pkg::ST_SUM1_RD;
               end
            end
         end
         // weighted sums of lower and upper
         ibt_pkg::ST_SUM1_RD: state_in = ibt_pkg::ST_SUM1_ACC;
         ibt_pkg::ST_SUM1_ACC: begin
            acc1_in = ibt_pkg::sadd(acc1_ff, prod_lo);
            acc2_in = ibt_pkg::sadd(acc2_ff, prod_up);
            idx_in = idx_ff + CW'(1);
            if (last_idx) begin
               idx_in = '0; state_in = ibt_pkg::ST_P1_RD;
            end else state_in = ibt_pkg::ST_SUM1_RD;
         end
         // phase one per variable
         ibt_pkg::ST_P1_RD: state_in = ibt_pkg::ST_P1_DIVU;
         ibt_pkg::ST_P1_DIVU: begin
            lo_in = lo_r; up_in = up_r;
            if (g_r == 32'sd0) state_in = ibt_pkg::ST_P1_WR;
            else begin
               dreq.start = 1'b1; dreq.num = t_lo; dreq.den = g_r;
               state_in = ibt_pkg::ST_P1_WAITU;
            end
         end
         ibt_pkg::ST_P1_WAITU: if (drsp.done) begin
            cand = ibt_pkg::clamp32(64'(lo_ff) + 64'(drsp.quot));
            if (cand < up_ff) begin
               up_in = cand; chg_in = 1'b1;
            end
            state_in = ibt_pkg::ST_P1_DIVL;
         end
         ibt_pkg::ST_P1_DIVL: begin
            dreq.start = 1'b1; dreq.num = t_up; dreq.den = g_r;
            state_in = ibt_pkg::ST_P1_WAITL;
         end
         ibt_pkg::ST_P1_WAITL: if (drsp.done) begin
            cand = ibt_pkg::clamp32(64'(up_ff) - 64'(drsp.quot));
            if (cand > lo_ff) begin
               lo_in = cand; chg_in = 1'b1;
            end
            state_in = ibt_pkg::ST_P1_WR;
         end
         ibt_pkg::ST_P1_WR: begin
            we = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (last_idx) begin
               idx_in = '0; acc1_in = '0; state_in = ibt_pkg::ST_SUM2_RD;
            end else state_in = ibt_pkg::ST_P1_RD;
         end
         // return sum
         ibt_pkg::ST_SUM2_RD: state_in = ibt_pkg::ST_SUM2_ACC;
         ibt_pkg::ST_SUM2_ACC: begin
            if (r_r != 32'sd0) acc1_in = ibt_pkg::sadd(acc1_ff, prod_r);
            idx_in = idx_ff + CW'(1);
            if (last_idx) begin
               idx_in = '0; state_in = ibt_pkg::ST_P2_RD;
            end else state_in = ibt_pkg::ST_SUM2_RD;
         end
         // phase two per variable; delta/(-r) is taken as (-delta)/r
         ibt_pkg::ST_P2_RD: state_in = ibt_pkg::ST_P2_DIV;
         ibt_pkg::ST_P2_DIV: begin
            lo_in = lo_r; up_in = up_r;
            if (r_r == 32'sd0) state_in = ibt_pkg::ST_P2_WR;
            else begin
               dreq.start = 1'b1;
               dreq.num = r_r[31] ? -delta : delta;
               dreq.den = r_r;
               state_in = ibt_pkg::ST_P2_WAIT;
            end
         end
         ibt_pkg::ST_P2_WAIT: if (drsp.done) begin
            if (!r_r[31]) begin
               cand = ibt_pkg::clamp32(64'(up_ff) - 64'(drsp.quot));
               if (cand > lo_ff) begin
                  lo_in = cand; chg_in = 1'b1;
               end
            end else begin
               cand = ibt_pkg::clamp32(64'(lo_ff) + 64'(drsp.quot));
               if (cand < up_ff) begin
                  up_in = cand; chg_in = 1'b1;
               end
            end
            state_in = ibt_pkg::ST_P2_WR;
         end
         ibt_pkg::ST_P2_WR: begin
            we = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (last_idx) begin
               idx_in = '0; inf_in = 1'b0; state_in = ibt_pkg::ST_CHK_RD;
            end else state_in = ibt_pkg::ST_P2_RD;
         end
         // feasibility scan
         ibt_pkg::ST_CHK_RD: state_in = ibt_pkg::ST_CHK;
         ibt_pkg::ST_CHK: begin
            if (up_r < lo_r) inf_in = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (last_idx) begin
               idx_in = '0; state_in = ibt_pkg::ST_DECIDE;
            end else state_in = ibt_pkg::ST_CHK_RD;
         end
         ibt_pkg::ST_DECIDE: begin
            rounds_in = rounds_ff + 16'd1;
            if (inf_ff) begin
               status_in = ibt_pkg::StatusInfeasible; state_in = ibt_pkg::ST_OUT_RD;
            end else if (!chg_ff) begin
               status_in = ibt_pkg::StatusConverged; state_in = ibt_pkg::ST_OUT_RD;
            end else if (rounds_ff + 16'd1 >= limit) begin
               status_in = ibt_pkg::StatusLimit; state_in = ibt_pkg::ST_OUT_RD;
            end else begin
               acc1_in = '0; acc2_in = '0; chg_in = 1'b0;
               state_in = ibt_pkg::ST_SUM1_RD;
            end
         end
         // result transfers
         ibt_pkg::ST_OUT_RD: state_in = ibt_pkg::ST_OUT;
         ibt_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + CW'(1);
               if (last_idx) begin
                  idx_in = '0; state_in = ibt_pkg::ST_LOAD;
               end else state_in = ibt_pkg::ST_OUT_RD;
            end
         end
         default: state_in = ibt_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      acc1_ff <= acc1_in; acc2_ff <= acc2_in; lo_ff <= lo_in; up_ff <= up_in;
      n_ff <= n_in; rounds_ff <= rounds_in; inf_ff <= inf_in; chg_ff <= chg_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff <= ibt_pkg::ST_LOAD; count_ff <= '0; idx_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; idx_ff <= idx_in;
      end
   end

   assign rsp_data.out_index  = 6'(idx_ff);
   assign rsp_data.lower_out  = lo_r;
   assign rsp_data.upper_out  = up_r;
   assign rsp_data.end_status = status_ff;
   assign rsp_data.out_last   = last_idx;

`ifndef SYNTH
   a_ready_only_load: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ibt_pkg::ST_LOAD) else $error("ready outside load");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VARS)) else $error("loaded count overflow");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("load and send at once");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> idx_ff < n_ff) else $error("result index past count");
`endif

endmodule

FILE: src/ibt_div.sv
// Radix-2 floor divider: 64-bit numerator by 32-bit divisor, 32-bit saturated quotient.
module ibt_div (
   input  logic                clock,
   input  logic                reset,
   input  ibt_pkg::div_req_type dreq,
   output ibt_pkg::div_rsp_type drsp
);

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic        done_ff, done_in;

   logic [63:0] nabs;
   logic [31:0] dabs;
   logic [33:0] trial;
   logic        nz;
   logic [64:0] q65;
   logic signed [64:0] qs;

   assign nabs = dreq.num[63] ? 64'(-dreq.num) : dreq.num;
   assign dabs = dreq.den[31] ? 32'(-dreq.den) : dreq.den;
   assign trial = {rem_ff, quo_ff[63]} - {2'b00, den_ff};
   // floor correction: magnitude quotient plus one when signs differ and remainder nonzero
   assign nz = (rem_ff != 33'd0);
   assign q65 = {1'b0, quo_ff} + ((nneg_ff != dneg_ff && nz) ? 65'd1 : 65'd0);
   assign qs = (nneg_ff != dneg_ff) ? -$signed(q65) : $signed(q65);

   // one quotient bit per cycle
   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; nneg_in = nneg_ff; dneg_in = dneg_ff; done_in = 1'b0;
      if (dreq.start) begin
         quo_in = nabs; rem_in = '0; den_in = dabs; cnt_in = 7'd64; busy_in = 1'b1;
         nneg_in = dreq.num[63]; dneg_in = dreq.den[31];
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0]; quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]}; quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      nneg_ff <= nneg_in; dneg_ff <= dneg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign drsp.done = done_ff;
   assign drsp.quot = (qs > 65'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (qs < -65'sh8000_0000) ? 32'sh8000_0000 : qs[31:0];

`ifndef SYNTH
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done not a pulse");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      dreq.start |=> busy_ff) else $error("divider did not start");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 7'd0) else $error("divider count ran out while busy");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the integer bound tightening block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     VarSlots  = 64;
   localparam int     FracBits  = 16;
   localparam int     StallLimit = 400000;
   localparam longint SumMax    = 64'sh7FFF_FFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ibt_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   ibt_pkg::rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [ibt_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   integer_bound_tightening_top u_top (.*);

   // bound store and settings of the predictor
   longint      wt_tab[VarSlots];
   longint      ret_tab[VarSlots];
   longint      lo_tab[VarSlots];
   longint      hi_tab[VarSlots];
   int unsigned vars_held = 0;
   longint      wfloor_cfg = 0;
   longint      target_cfg = 0;
   int unsigned rounds_cfg = 1024;

   ibt_pkg::req_type var_queue[$];
   ibt_pkg::rsp_type bound_queue[$];
   int          errors = 0;
   int          items_sent = 0;
   int          sets_sent = 0;
   int          bounds_seen = 0;
   int          load_pos = 0;
   int          send_gap = 0;
   int          recv_hold = 0;
   int          idle_cycles = 0;

   initial forever #4 clock = ~clock;

   // saturating add into the symmetric 64-bit range
   function automatic longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > SumMax) return SumMax;
      if (s < -SumMax) return -SumMax;
      return longint'(s);
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
      return clip32(q);
   endfunction

   // rounds of tightening over the first n held variables
   function automatic logic [1:0] tighten(int unsigned n);
      int unsigned lim, rounds;
      longint      slo, sup, t_lo, t_up, delta, nb, c;
      bit          changed, infeasible;
      lim = (rounds_cfg == 0) ? 1 : rounds_cfg;
      rounds = 0;
      forever begin
         changed = 0;
         infeasible = 0;
         slo = 0;
         sup = 0;
         delta = 0;
         for (int i = 0; i < n; i++) begin
            slo = sat_add(slo, lo_tab[i] * wt_tab[i]);
            sup = sat_add(sup, hi_tab[i] * wt_tab[i]);
         end
         t_lo = sat_add(longint'(1) << FracBits, -slo);
         t_up = sat_add(sup, -wfloor_cfg);
         // weight constraint, new upper feeds the lower
         for (int i = 0; i < n; i++) begin
            c = wt_tab[i];
            if (c != 0) begin
               nb = clip32(lo_tab[i] + floor_quot(t_lo, c));
               if (nb < hi_tab[i]) begin
                  hi_tab[i] = nb;
                  changed = 1;
               end
               nb = clip32(hi_tab[i] - floor_quot(t_up, c));
               if (nb > lo_tab[i]) begin
                  lo_tab[i] = nb;
                  changed = 1;
               end
            end
         end
         // return constraint
         for (int i = 0; i < n; i++) begin
            if (ret_tab[i] < 0) delta = sat_add(delta, ret_tab[i] * lo_tab[i]);
            else if (ret_tab[i] > 0) delta = sat_add(delta, ret_tab[i] * hi_tab[i]);
         end
         delta = sat_add(delta, -target_cfg);
         for (int i = 0; i < n; i++) begin
            c = ret_tab[i];
            if (c > 0) begin
               nb = clip32(hi_tab[i] - floor_quot(delta, c));
               if (nb > lo_tab[i]) begin
                  lo_tab[i] = nb;
                  changed = 1;
               end
            end else if (c < 0) begin
               nb = clip32(lo_tab[i] + floor_quot(delta, -c));
               if (nb < hi_tab[i]) begin
                  hi_tab[i] = nb;
                  changed = 1;
               end
            end
         end
         for (int i = 0; i < n; i++)
            if (hi_tab[i] < lo_tab[i]) infeasible = 1;
         rounds++;
         if (infeasible) return ibt_pkg::StatusInfeasible;
         if (!changed) return ibt_pkg::StatusConverged;
         if (rounds >= lim) return ibt_pkg::StatusLimit;
      end
   endfunction

   // store one accepted variable; the final one yields the tightened bounds
   function automatic void absorb_var(ibt_pkg::req_type it);
      int unsigned n;
      logic [1:0]  st;
      ibt_pkg::rsp_type r;
      if (vars_held < VarSlots) begin
         wt_tab[vars_held]  = longint'(it.weight);
         ret_tab[vars_held] = longint'(it.ret_coef);
         lo_tab[vars_held]  = longint'(it.lower_in);
         hi_tab[vars_held]  = longint'(it.upper_in);
         vars_held++;
      end
      if (!it.load_last) return;
      n = vars_held;
      vars_held = 0;
      if (n == 0) return;
      st = tighten(n);
      for (int k = 0; k < n; k++) begin
         r.out_index  = k[5:0];
         r.lower_out  = lo_tab[k][31:0];
         r.upper_out  = hi_tab[k][31:0];
         r.end_status = st;
         r.out_last   = (k + 1 == n);
         bound_queue.push_back(r);
      end
   endfunction

   // driver: request transfers with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         absorb_var(req_data);
         send_gap = $urandom_range(0, 4);
         if (send_gap == 0 && var_queue.size() > 0) begin
            req_data <= var_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (var_queue.size() > 0) begin
            req_data  <= var_queue.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // monitor: response transfers checked against predicted bounds
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         bounds_seen++;
         if (bound_queue.size() == 0) begin
            $error("unexpected result for index %0d", rsp_data.out_index);
            errors++;
         end else begin
            ibt_pkg::rsp_type e;
            e = bound_queue.pop_front();
            if (rsp_data.out_index !== e.out_index) begin
               $error("out_index exp %0d got %0d", e.out_index, rsp_data.out_index);
               errors++;
            end
            if (rsp_data.lower_out !== e.lower_out) begin
               $error("lower_out exp %0d got %0d", e.lower_out, rsp_data.lower_out);
               errors++;
            end
            if (rsp_data.upper_out !== e.upper_out) begin
               $error("upper_out exp %0d got %0d", e.upper_out, rsp_data.upper_out);
               errors++;
            end
            if (rsp_data.end_status !== e.end_status) begin
               $error("end_status exp %0d got %0d", e.end_status, rsp_data.end_status);
               errors++;
            end
            if (rsp_data.out_last !== e.out_last) begin
               $error("out_last exp %0d got %0d", e.out_last, rsp_data.out_last);
               errors++;
            end
         end
         recv_hold = $urandom_range(0, 4);
         rsp_ready <= (recv_hold == 0);
      end else if (recv_hold > 0) begin
         recv_hold--;
         rsp_ready <= (recv_hold == 0);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic reg_write(input logic [ibt_pkg::CsrAddrWidth-1:0] a,
                            input logic [31:0] d);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr  <= a;
      csr_pwdata <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (a)
         ibt_pkg::AddrWeightFloor:  wfloor_cfg = longint'($signed(d));
         ibt_pkg::AddrReturnTarget: target_cfg = longint'($signed(d));
         ibt_pkg::AddrRoundLimit:   rounds_cfg = 32'(d[15:0]);
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [31:0] wf, input logic [31:0] rt,
                           input logic [31:0] rl);
      reg_write(ibt_pkg::AddrWeightFloor, wf);
      reg_write(ibt_pkg::AddrReturnTarget, rt);
      reg_write(ibt_pkg::AddrRoundLimit, rl);
   endtask

   task automatic add_var(input logic [31:0] w, input logic [31:0] r,
                          input logic [31:0] l, input logic [31:0] u, input bit last);
      ibt_pkg::req_type it;
      it.var_index = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'(load_pos);
      it.weight    = w;
      it.ret_coef  = r;
      it.lower_in  = l;
      it.upper_in  = u;
      it.load_last = last;
      var_queue.push_back(it);
      items_sent++;
      load_pos = last ? 0 : load_pos + 1;
      if (last) sets_sent++;
   endtask

   // wait until every transfer is done and the block has settled
   task automatic drain();
      while (var_queue.size() > 0 || req_valid || bound_queue.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] small_coef();
      if ($urandom_range(0, 5) == 0) return 32'd0;
      return 32'($urandom_range(0, 8 << FracBits)) - 32'(4 << FracBits);
   endfunction

   // one set of n variables; noisy sets use full-range fields for randomly chosen variables
   task automatic add_set(input int n, input bit noisy);
      logic [31:0] l;
      for (int k = 0; k < n; k++) begin
         if (noisy && $urandom_range(0, 1)) begin
            add_var($urandom, $urandom, $urandom, $urandom, k == n - 1);
         end else begin
            l = 32'($urandom_range(0, 200)) - 32'd100;
            add_var(small_coef(), small_coef(), l,
                    l + 32'($urandom_range(0, 300)) - 32'd20, k == n - 1);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: round limit zero behaves as one, zero divisors
      set_regs(32'd0, 32'd0, 32'd0);
      add_var(32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      add_var(32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'd10, 1'b0);
      add_var(32'h0002_0000, 32'h0003_0000, 32'd5, 32'd40, 1'b1);
      drain();

      set_regs(32'h0000_8000, 32'hFFFF_0000, 32'd4);
      // coefficient and bound extremes
      add_var(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      add_var(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      add_var(32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
      // infeasible from the start
      add_var(32'h0001_0000, 32'h0001_0000, 32'd10, 32'd5, 1'b1);
      // some non-final items then the final one
      add_var(32'h0001_0000, 32'h0000_0000, 32'd0, 32'd100, 1'b0);
      add_var(32'hFFFF_0000, 32'h0002_0000, -32'd50, 32'd50, 1'b0);
      add_var(32'h0000_0000, 32'hFFFE_0000, -32'd3, 32'd3, 1'b1);
      drain();

      set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
      add_var(32'h0004_0000, 32'h0004_0000, -32'd100, 32'd100, 1'b0);
      add_var(32'hFFFC_0000, 32'hFFFC_0000, -32'd100, 32'd100, 1'b1);
      drain();

      // largest round limit with no coefficients settles in one round
      set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_var(32'd0, 32'd0, -32'd7, 32'd7, 1'b0);
      add_var(32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      add_var(32'd0, 32'd0, 32'd1, 32'd2, 1'b1);
      drain();

      // store overflow: items beyond the store are dropped
      set_regs(32'h0001_0000, 32'hFFF0_0000, 32'd2);
      add_set(VarSlots + 2, 1'b0);
      drain();

      // random phases
      while (items_sent < 200) begin
         set_regs($urandom_range(0, 3) == 0 ? $urandom : small_coef() * 4,
                  $urandom_range(0, 3) == 0 ? $urandom : small_coef() * 4,
                  $urandom_range(1, 12));
         repeat ($urandom_range(3, 6))
            add_set($urandom_range(1, 8), $urandom_range(0, 4) == 0);
         drain();
      end

      $display("Ran %0d variable sets (%0d items) and checked %0d bound results.",
               sets_sent, items_sent, bounds_seen);
      $display("Settings covered round limits 0 to 65535 and extreme floor and target.");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

FILE: filelist.f
src/ibt_pkg.sv
src/ibt_div.sv
src/integer_bound_tightening_top.sv
verif/tb.sv
